[hw/rtl/gha_pkg.sv]
package gha_pkg;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_RELEASE = 3'd1,
        OP_RESIZE  = 3'd2,
        OP_LOOKUP  = 3'd3,
        OP_ACQUIRE = 3'd4,
        OP_VP_REL  = 3'd5,
        OP_QUERY   = 3'd6,
        OP_NOP     = 3'd7
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_EXEC = 5'b00100,
        ST_BIND = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

endpackage

[hw/rtl/generational_handle_allocator_unit.sv]
// Generational handle allocator.
// Command channel: a word (opcode, handle, viewport, width, height, alloc_ok)
// is taken on a rising edge with start high and busy low. busy then stays
// high until the result word is shown.
// Result channel: done is high for exactly one cycle with result_handle,
// success, width_out, height_out, live_count and allocations_made. The
// receiver cannot hold a result off; it must take it in that cycle.
// Handles carry the slot generation in bits 31..16 and slot number plus one
// in bits 15..0; zero means no target.
// One item is in flight at a time, so no new word is taken before the last
// result is shown. The binding table is scanned one entry a cycle by a
// single comparator.
// Scan: the binding match (by target handle for a release, by viewport
// otherwise) and the first free binding entry are found in the same pass.
// Execution then updates the slot table, a bind write follows,
// and the result is read out of the updated table.
// Reset: all slots dead at generation zero, no bindings, counters zero.
// Free stack and binding payload are undefined until written.
module generational_handle_allocator_unit #(
    parameter int MAX_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] handle,
    input  logic [31:0] viewport,
    input  logic [15:0] width,
    input  logic [15:0] height,
    input  logic        alloc_ok,
    output logic        done,
    output logic [31:0] result_handle,
    output logic        success,
    output logic [15:0] width_out,
    output logic [15:0] height_out,
    output logic [4:0]  live_count,
    output logic [31:0] allocations_made
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 1);

    gha_pkg::state_t state_reg, state_next;

    // slot table
    logic [15:0] gen_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] live_reg;
    logic [31:0] ext_reg [MAX_SLOTS];
    logic [IW-1:0] stack_mem [MAX_SLOTS];
    logic [CW-1:0] fdepth_reg, used_reg;
    logic [4:0]  live_tot_reg;
    logic [31:0] created_reg;

    // binding table
    logic [31:0] bvp_mem [MAX_SLOTS];
    logic [31:0] btg_mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0] bvalid_reg;

    // latched command
    logic [2:0]  op_reg;
    logic [31:0] h_reg, vp_reg, ext_in_reg;
    logic        ok_reg;

    // scan
    logic [IW-1:0] scan_reg;
    logic          hit_reg, freef_reg;
    logic [IW-1:0] hit_idx_reg, free_idx_reg;
    logic [31:0]   res_reg;
    logic          succ_reg;

    logic scan_last;
    assign scan_last = ({{(32-IW){1'b0}}, scan_reg} == 32'(MAX_SLOTS - 1));

    // one comparator: a release matches on target handle, the rest on viewport
    logic [31:0] scan_key, scan_ref;
    always_comb
    begin
        if (op_reg == gha_pkg::OP_RELEASE)
        begin
            scan_key = btg_mem[scan_reg];
            scan_ref = h_reg;
        end
        else
        begin
            scan_key = bvp_mem[scan_reg];
            scan_ref = vp_reg;
        end
    end

    // resolve handle with generation check
    logic [31:0] tgt_h;
    logic [15:0] tgt_s;
    logic [IW-1:0] tgt_i;
    logic tgt_ok;

    logic empty;
    assign empty = (ext_in_reg[15:0] == 16'd0) || (ext_in_reg[31:16] == 16'd0);

    always_comb
    begin
        if (op_reg == gha_pkg::OP_ACQUIRE || op_reg == gha_pkg::OP_VP_REL)
            tgt_h = btg_mem[hit_idx_reg];
        else
            tgt_h = h_reg;
        tgt_s = tgt_h[15:0];
        tgt_i = IW'(tgt_s - 16'd1);
        tgt_ok = (tgt_s != 16'd0) && ({16'd0, tgt_s} <= 32'(used_reg)) &&
                 ({16'd0, tgt_s} <= 32'(MAX_SLOTS)) && live_reg[tgt_i] &&
                 (gen_reg[tgt_i] == tgt_h[31:16]);
    end

    // result resolution after update
    logic [15:0] rs;
    logic [IW-1:0] ri;
    logic r_ok;
    always_comb
    begin
        rs = res_reg[15:0];
        ri = IW'(rs - 16'd1);
        r_ok = (rs != 16'd0) && ({16'd0, rs} <= 32'(used_reg)) &&
               ({16'd0, rs} <= 32'(MAX_SLOTS)) && live_reg[ri] &&
               (gen_reg[ri] == res_reg[31:16]);
    end

    logic [31:0] created_inc;
    assign created_inc = (created_reg > (gha_pkg::CNT_MAX - 32'd2)) ?
                         gha_pkg::CNT_MAX : created_reg + 32'd2;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gha_pkg::ST_IDLE: if (start) state_next = gha_pkg::ST_SCAN;
            gha_pkg::ST_SCAN: if (scan_last) state_next = gha_pkg::ST_EXEC;
            gha_pkg::ST_EXEC: state_next = gha_pkg::ST_BIND;
            gha_pkg::ST_BIND: state_next = gha_pkg::ST_DONE;
            gha_pkg::ST_DONE: state_next = gha_pkg::ST_IDLE;
            default:          state_next = gha_pkg::ST_IDLE;
        endcase
    end

    assign busy = (state_reg != gha_pkg::ST_IDLE);

    // the create path, shared by create and acquire
    logic          cr_go, cr_pop, cr_new;
    logic [IW-1:0] cr_idx;
    always_comb
    begin
        cr_pop = (fdepth_reg != '0);
        cr_new = !cr_pop && (32'(used_reg) < 32'(MAX_SLOTS));
        cr_idx = cr_pop ? stack_mem[IW'(fdepth_reg - CW'(1))] : IW'(used_reg);
        cr_go  = !empty && (cr_pop || cr_new);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= gha_pkg::ST_IDLE;
            live_reg     <= '0;
            bvalid_reg   <= '0;
            fdepth_reg   <= '0;
            used_reg     <= '0;
            live_tot_reg <= '0;
            created_reg  <= '0;
            done         <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                gen_reg[i] <= '0;
                ext_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == gha_pkg::ST_DONE);
            unique case (state_reg)
                gha_pkg::ST_IDLE:
                begin
                    if (start)
                    begin
                        op_reg     <= opcode;
                        h_reg      <= handle;
                        vp_reg     <= viewport;
                        ext_in_reg <= {height, width};
                        ok_reg     <= alloc_ok;
                        scan_reg   <= '0;
                        hit_reg    <= 1'b0;
                        freef_reg  <= 1'b0;
                        res_reg    <= '0;
                        succ_reg   <= 1'b0;
                    end
                end
                gha_pkg::ST_SCAN:
                begin
                    if (!hit_reg && bvalid_reg[scan_reg] && scan_key == scan_ref)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= scan_reg;
                    end
                    if (!freef_reg && !bvalid_reg[scan_reg])
                    begin
                        freef_reg    <= 1'b1;
                        free_idx_reg <= scan_reg;
                    end
                    scan_reg <= scan_reg + IW'(1);
                end
                gha_pkg::ST_EXEC:
                begin
                    unique case (op_reg) inside
                        gha_pkg::OP_CREATE, gha_pkg::OP_ACQUIRE:
                        begin
                            if (op_reg == gha_pkg::OP_ACQUIRE && hit_reg)
                            begin
                                if (empty)
                                    res_reg <= tgt_h;
                                else if (tgt_ok)
                                begin
                                    if (ext_reg[tgt_i] == ext_in_reg)
                                        res_reg <= tgt_h;
                                    else if (ok_reg)
                                    begin
                                        res_reg         <= tgt_h;
                                        created_reg     <= created_inc;
                                        ext_reg[tgt_i]  <= ext_in_reg;
                                    end
                                end
                            end
                            else if (cr_go)
                            begin
                                if (cr_new)
                                begin
                                    used_reg        <= used_reg + CW'(1);
                                    gen_reg[cr_idx] <= '0;
                                end
                                if (ok_reg)
                                begin
                                    if (cr_pop) fdepth_reg <= fdepth_reg - CW'(1);
                                    created_reg      <= created_inc;
                                    ext_reg[cr_idx]  <= ext_in_reg;
                                    live_reg[cr_idx] <= 1'b1;
                                    live_tot_reg     <= live_tot_reg + 5'd1;
                                    res_reg <= {cr_new ? 16'd0 : gen_reg[cr_idx],
                                                16'(32'(cr_idx) + 1)};
                                end
                                else
                                begin
                                    live_reg[cr_idx] <= 1'b0;
                                    if (cr_new)
                                    begin
                                        ext_reg[cr_idx] <= '0;
                                        if (32'(fdepth_reg) < 32'(MAX_SLOTS))
                                        begin
                                            stack_mem[IW'(fdepth_reg)] <= cr_idx;
                                            fdepth_reg <= fdepth_reg + CW'(1);
                                        end
                                    end
                                end
                            end
                        end
                        gha_pkg::OP_RELEASE, gha_pkg::OP_VP_REL:
                        begin
                            if ((op_reg == gha_pkg::OP_RELEASE || hit_reg) && tgt_ok)
                            begin
                                succ_reg         <= 1'b1;
                                ext_reg[tgt_i]   <= '0;
                                live_reg[tgt_i]  <= 1'b0;
                                gen_reg[tgt_i]   <= gen_reg[tgt_i] + 16'd1;
                                live_tot_reg     <= live_tot_reg - 5'd1;
                                if (32'(fdepth_reg) < 32'(MAX_SLOTS))
                                begin
                                    stack_mem[IW'(fdepth_reg)] <= tgt_i;
                                    fdepth_reg <= fdepth_reg + CW'(1);
                                end
                                // hit already points at the binding that holds the target
                            end
                            else
                                hit_reg <= 1'b0;
                        end
                        gha_pkg::OP_RESIZE:
                        begin
                            if (tgt_ok)
                            begin
                                res_reg <= h_reg;
                                if (empty || ext_reg[tgt_i] == ext_in_reg)
                                    succ_reg <= 1'b1;
                                else if (ok_reg)
                                begin
                                    succ_reg       <= 1'b1;
                                    created_reg    <= created_inc;
                                    ext_reg[tgt_i] <= ext_in_reg;
                                end
                            end
                        end
                        gha_pkg::OP_LOOKUP:
                        begin
                            if (tgt_ok)
                            begin
                                res_reg  <= h_reg;
                                succ_reg <= 1'b1;
                            end
                        end
                        gha_pkg::OP_QUERY:
                        begin
                            if (hit_reg)
                                res_reg <= btg_mem[hit_idx_reg];
                        end
                        default: ;
                    endcase
                end
                gha_pkg::ST_BIND:
                begin
                    if ((op_reg == gha_pkg::OP_RELEASE || op_reg == gha_pkg::OP_VP_REL)
                        && hit_reg)
                        bvalid_reg[hit_idx_reg] <= 1'b0;
                    if (op_reg == gha_pkg::OP_ACQUIRE && !hit_reg && freef_reg &&
                        res_reg != '0)
                    begin
                        bvalid_reg[free_idx_reg] <= 1'b1;
                        bvp_mem[free_idx_reg]    <= vp_reg;
                        btg_mem[free_idx_reg]    <= res_reg;
                    end
                    if (op_reg == gha_pkg::OP_CREATE || op_reg == gha_pkg::OP_ACQUIRE ||
                        op_reg == gha_pkg::OP_QUERY)
                        succ_reg <= (res_reg != '0);
                end
                gha_pkg::ST_DONE:
                begin
                    result_handle    <= res_reg;
                    success          <= succ_reg;
                    width_out        <= r_ok ? ext_reg[ri][15:0] : 16'd0;
                    height_out       <= r_ok ? ext_reg[ri][31:16] : 16'd0;
                    live_count       <= live_tot_reg;
                    allocations_made <= created_reg;
                end
                default: ;
            endcase
        end
    end

    // assertions
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("done while busy");
    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(live_tot_reg) <= 32'(used_reg)) else $error("live above used");
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= 32'(MAX_SLOTS)) else $error("used overflow");

endmodule
